// ----- src/fat_cluster_chain_allocator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Cluster chain allocator - assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_TOP_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_TOP_DEFINES_SVH

// Assert that a property holds at every clock edge out of reset
`define FCCA_CHECK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Assert that a condition never holds out of reset
`define FCCA_NEVER(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- src/fcca_pkg.sv -----
// ----------------------------------------------------------------------------
// Cluster chain allocator - package
// Widths, codes, state encoding and table constants shared by the design, checker and testbench files.
// ----------------------------------------------------------------------------
package fcca_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES_DEF  = 4096;
    localparam int ENTRIES_PER_SECTOR = 512 / 4;
    localparam int SECTOR_SHIFT       = $clog2(ENTRIES_PER_SECTOR);
    localparam int RESET_SECTORS      = 32;

    // Field widths
    localparam int SECTORS_W = 6;
    localparam int ACTION_W  = 2;
    localparam int CLUSTER_W = 12;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;

    // End-of-chain marker
    localparam logic [DATA_W-1:0] CHAIN_END = 32'h0FFF_FFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NEXT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_USE,
        ST_WRITE,
        ST_SCAN,
        ST_MARK,
        ST_LINK,
        ST_RESP
    } t_state;

    // Memory port strobes from controller to table RAM
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ----- src/fcca_if.sv -----
// ----------------------------------------------------------------------------
// Cluster chain allocator - channel interfaces
// Valid/ready channels for request words, result words and configuration.
// ----------------------------------------------------------------------------
interface fcca_in_if;
    logic                          valid;
    logic                          ready;
    logic [fcca_pkg::ACTION_W-1:0]  action;
    logic [fcca_pkg::CLUSTER_W-1:0] cluster;
    logic [fcca_pkg::DATA_W-1:0]    entry_value;

    modport source (output valid, action, cluster, entry_value, input ready);
    modport sink   (input valid, action, cluster, entry_value, output ready);
endinterface

interface fcca_out_if;
    logic                         valid;
    logic                         ready;
    logic [fcca_pkg::DATA_W-1:0]   result_value;
    logic [fcca_pkg::STATUS_W-1:0] status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

interface fcca_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fcca_pkg::SECTORS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/fcca_ram.sv -----
// ----------------------------------------------------------------------------
// Cluster chain allocator - table RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fcca_ram #(
    parameter int DEPTH = fcca_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  fcca_pkg::t_mem_ctl          i_ctl,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  logic [fcca_pkg::DATA_W-1:0] i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr,
    output logic [fcca_pkg::DATA_W-1:0] o_rd_data
);
    import fcca_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/fcca_ctrl.sv -----
// ----------------------------------------------------------------------------
// Cluster chain allocator - controller
// Sequences lookups, free-entry scans and write-backs against the table RAM,
// holds the entry limit set from the sector count and the output word register.
// ----------------------------------------------------------------------------
module fcca_ctrl #(
    parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fcca_in_if.sink                            i_in,
    fcca_out_if.source                         o_out,
    fcca_cfg_if.sink                           i_cfg,
    output fcca_pkg::t_mem_ctl                 o_mem_ctl,
    output logic [$clog2(TABLE_ENTRIES)-1:0]   o_wr_addr,
    output logic [fcca_pkg::DATA_W-1:0]        o_wr_data,
    output logic [$clog2(TABLE_ENTRIES)-1:0]   o_rd_addr,
    input  logic [fcca_pkg::DATA_W-1:0]        i_rd_data
);
    import fcca_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    // Wide enough for the entry count itself and for sectors * 128
    localparam int LW = (AW + 1 > SECTORS_W + SECTOR_SHIFT) ? AW + 1
                                                            : SECTORS_W + SECTOR_SHIFT;
    localparam int RST_PROD = RESET_SECTORS * ENTRIES_PER_SECTOR;
    localparam logic [LW-1:0] TBL_MAX   = LW'(TABLE_ENTRIES);
    localparam logic [LW-1:0] RST_LIMIT =
        LW'((RST_PROD > TABLE_ENTRIES) ? TABLE_ENTRIES : RST_PROD);

    t_state            r_state, n_state;
    logic [LW-1:0]     r_limit, n_limit;
    t_action           r_act, n_act;
    logic [AW-1:0]     r_cl, n_cl;
    logic [DATA_W-1:0] r_val, n_val;
    logic              r_link, n_link;
    logic [LW-1:0]     r_issue, n_issue;
    logic              r_chk_vld, n_chk_vld;
    logic [AW-1:0]     r_chk_addr, n_chk_addr;
    logic [AW-1:0]     r_found, n_found;
    logic [DATA_W-1:0] r_res_val, n_res_val;
    t_status           r_res_st, n_res_st;
    logic              r_out_vld, n_out_vld;
    logic [DATA_W-1:0] r_o_val, n_o_val;
    t_status           r_o_st, n_o_st;

    logic [LW-1:0]     w_prod;
    logic [LW-1:0]     w_cl_ext;
    logic              w_in_range;
    logic              w_in_acc;
    logic              w_out_take;
    logic              w_more;

    assign w_prod     = LW'(i_cfg.data) << SECTOR_SHIFT;
    assign w_cl_ext   = LW'(i_in.cluster);
    assign w_in_range = w_cl_ext < r_limit;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_take = r_out_vld && o_out.ready;
    assign w_more     = r_issue < r_limit;

    assign i_cfg.ready        = 1'b1;
    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_vld;
    assign o_out.result_value = r_o_val;
    assign o_out.status       = r_o_st;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_limit   <= RST_LIMIT;
            r_out_vld <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_limit   <= n_limit;
            r_out_vld <= n_out_vld;
            r_chk_vld <= n_chk_vld;
        end
    end

    // Hold item and result payload
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_cl       <= n_cl;
        r_val      <= n_val;
        r_link     <= n_link;
        r_issue    <= n_issue;
        r_chk_addr <= n_chk_addr;
        r_found    <= n_found;
        r_res_val  <= n_res_val;
        r_res_st   <= n_res_st;
        r_o_val    <= n_o_val;
        r_o_st     <= n_o_st;
    end

    // Next state, memory accesses and result
    always_comb begin
        n_state    = r_state;
        n_limit    = r_limit;
        n_act      = r_act;
        n_cl       = r_cl;
        n_val      = r_val;
        n_link     = r_link;
        n_issue    = r_issue;
        n_chk_vld  = 1'b0;
        n_chk_addr = r_chk_addr;
        n_found    = r_found;
        n_res_val  = r_res_val;
        n_res_st   = r_res_st;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_o_val    = r_o_val;
        n_o_st     = r_o_st;
        o_mem_ctl  = '0;
        o_wr_addr  = r_cl;
        o_wr_data  = r_val;
        o_rd_addr  = r_cl;

        // Take a sector count write
        if (i_cfg.valid) begin
            n_limit = (w_prod > TBL_MAX) ? TBL_MAX : w_prod;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_act     = t_action'(i_in.action);
                    n_cl      = w_cl_ext[AW-1:0];
                    n_val     = i_in.entry_value;
                    n_link    = (i_in.cluster != '0);
                    n_issue   = '0;
                    n_res_val = '0;
                    n_res_st  = STAT_OK;
                    unique case (t_action'(i_in.action))
                        ACT_ALLOC: begin
                            if (i_in.cluster != '0 && !w_in_range) begin
                                n_res_st = STAT_RANGE;
                                n_state  = ST_RESP;
                            end else begin
                                n_state  = ST_SCAN;
                            end
                        end
                        ACT_WRITE: begin
                            n_res_st = w_in_range ? STAT_OK : STAT_RANGE;
                            n_state  = w_in_range ? ST_WRITE : ST_RESP;
                        end
                        default: begin
                            n_res_st = w_in_range ? STAT_OK : STAT_RANGE;
                            n_state  = w_in_range ? ST_LOOKUP : ST_RESP;
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                // Read the entry of the given cluster
                o_mem_ctl.rd_en = 1'b1;
                n_state         = ST_USE;
            end
            ST_USE: begin
                n_res_val = i_rd_data;
                if (r_act == ACT_FREE) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_wr_data       = '0;
                end
                n_state = ST_RESP;
            end
            ST_WRITE: begin
                o_mem_ctl.wr_en = 1'b1;
                n_state         = ST_RESP;
            end
            ST_SCAN: begin
                // Issue one read a cycle, check the word read the cycle before
                o_rd_addr = r_issue[AW-1:0];
                if (r_chk_vld && i_rd_data == '0) begin
                    n_found = r_chk_addr;
                    n_state = ST_MARK;
                end else if (w_more) begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_issue         = r_issue + 1'b1;
                    n_chk_vld       = 1'b1;
                    n_chk_addr      = r_issue[AW-1:0];
                end else if (!r_chk_vld) begin
                    n_res_st = STAT_FULL;
                    n_state  = ST_RESP;
                end
            end
            ST_MARK: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_found;
                o_wr_data       = CHAIN_END;
                n_res_val       = DATA_W'(r_found);
                n_state         = r_link ? ST_LINK : ST_RESP;
            end
            ST_LINK: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_data       = DATA_W'(r_found);
                n_state         = ST_RESP;
            end
            ST_RESP: begin
                // Load the output word register once it is free
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_o_val   = r_res_val;
                    n_o_st    = r_res_st;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_out_take && r_state != ST_RESP) begin
            n_out_vld = 1'b0;
        end
    end

endmodule

// ----- src/fat_cluster_chain_allocator_top.sv -----
// Sequence: next and free go through lookup, use and response; write_entry through write
// and response; an out-of-range word goes straight to response. Allocate scans the RAM,
// one entry per cycle, for a free entry (all entries in use when the table is full), then
// marks it and, with a link, writes the link before response. One word in work at a time;
// the next word can be taken in the cycle after the result word is loaded.
// Reset (synchronous, active low) clears control and sets 32 sectors; table keeps contents.
// ----------------------------------------------------------------------------
// Cluster chain allocator - top level
// Cluster table in one RAM, served by a read-modify-write controller.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_top #(
    parameter int TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcca_in_if.sink     i_in,
    fcca_out_if.source  o_out,
    fcca_cfg_if.sink    i_cfg
);
    import fcca_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    t_mem_ctl          w_mem_ctl;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [AW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;

    fcca_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_cfg     (i_cfg),
        .o_mem_ctl (w_mem_ctl),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    fcca_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

// ----- src/fcca_chk.sv -----
// ----------------------------------------------------------------------------
// Cluster chain allocator - port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "fat_cluster_chain_allocator_top_defines.svh"

module fcca_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_result_value,
    input logic [1:0]  i_status
);
    import fcca_pkg::*;

    // A stalled result word holds
    `FCCA_CHECK(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_value) && $stable(i_status), "result word changed while stalled")

    // Failures carry a zero value
    `FCCA_CHECK(a_fail_zero, i_out_valid && i_status != STAT_OK |-> i_result_value == '0, "failure with nonzero value")

    // Status stays within its codes
    `FCCA_NEVER(a_status_code, i_out_valid && i_status > STAT_RANGE, "undefined status code")

    // One word in work: no acceptance in the cycle after one
    `FCCA_CHECK(a_one_item, i_in_valid && i_in_ready |=> !i_in_ready, "word accepted while busy")

    // No result appears right after acceptance
    `FCCA_CHECK(a_no_early, i_in_valid && i_in_ready |=> !$rose(i_out_valid), "result word too early")

endmodule

bind fat_cluster_chain_allocator_top fcca_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_value (o_out.result_value),
    .i_status       (o_out.status)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster chain allocator - testbench
// Loads the cluster table, then sends request words for next, allocate, free
// and table writes under several sector counts, and checks every result word
// against an in-order shadow of the table. Words go out in random bursts
// while the result side stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module tb;
    import fcca_pkg::*;

    localparam int TABLE_SIZE  = TABLE_ENTRIES_DEF;
    localparam int LOADED_SPAN = ENTRIES_PER_SECTOR;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SHOWN_MAX   = 10;
    localparam int PHASE_WORDS = 3;

    typedef struct {
        logic [DATA_W-1:0] value;
        t_status           status;
    } chain_result_t;

    logic clk;
    logic rst_n;

    fcca_in_if  req_ch ();
    fcca_out_if rsp_ch ();
    fcca_cfg_if cfg_ch ();

    fat_cluster_chain_allocator_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow of the table, which entries hold known data, and the sector count
    logic [DATA_W-1:0]    shadow_table [TABLE_SIZE];
    bit                   written      [TABLE_SIZE];
    logic [SECTORS_W-1:0] shadow_sectors;
    chain_result_t        pending_results [$];

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned stray_count;
    int unsigned checked_count;
    int unsigned burst_left;
    int unsigned action_count [4];
    int unsigned status_count [4];

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------
    function automatic int unsigned entries_used();
        int unsigned n;
        n = int'(shadow_sectors) * ENTRIES_PER_SECTOR;
        return (n > TABLE_SIZE) ? TABLE_SIZE : n;
    endfunction

    // First entry in use that is free or still holds unknown data
    function automatic int unsigned scan_stop();
        int unsigned k;
        for (k = 0; k < entries_used(); k++) begin
            if (!written[k] || shadow_table[k] == '0)
                return k;
        end
        return entries_used();
    endfunction

    // Apply one request word to the shadow table and return its result word
    function automatic chain_result_t fat_apply(t_action act,
                                                logic [CLUSTER_W-1:0] cl,
                                                logic [DATA_W-1:0] val);
        chain_result_t r;
        int unsigned   lim;
        int unsigned   k;
        bit            in_use;
        lim      = entries_used();
        in_use   = (cl < lim);
        r.value  = '0;
        r.status = STAT_OK;
        case (act)
            ACT_NEXT: begin
                if (!in_use)
                    r.status = STAT_RANGE;
                else
                    r.value = shadow_table[cl];
            end
            ACT_ALLOC: begin
                if (cl != 0 && !in_use) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (k = 0; k < lim; k++) begin
                        if (shadow_table[k] == '0)
                            break;
                    end
                    if (k >= lim) begin
                        r.status = STAT_FULL;
                    end else begin
                        shadow_table[k] = CHAIN_END;
                        written[k]      = 1'b1;
                        // a self link overwrites the end mark just placed
                        if (cl != 0) begin
                            shadow_table[cl] = DATA_W'(k);
                            written[cl]      = 1'b1;
                        end
                        r.value = DATA_W'(k);
                    end
                end
            end
            ACT_FREE: begin
                if (!in_use) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.value          = shadow_table[cl];
                    shadow_table[cl] = '0;
                end
            end
            default: begin
                if (!in_use) begin
                    r.status = STAT_RANGE;
                end else begin
                    shadow_table[cl] = val;
                    written[cl]      = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [CLUSTER_W-1:0] pick_cluster(int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60 && lim > 0)
            return CLUSTER_W'($urandom_range(0, (lim > LOADED_SPAN) ? LOADED_SPAN - 1
                                                                      : lim - 1));
        if (r < 80)
            return CLUSTER_W'(lim - 1 + $urandom_range(0, 2));
        return CLUSTER_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return '0;
        if (r < 45)
            return CHAIN_END;
        if (r < 65)
            return DATA_W'($urandom_range(0, TABLE_SIZE - 1));
        return $urandom;
    endfunction

    // Send one request word in the current burst; returns at a falling edge
    task automatic send_word(t_action act, logic [CLUSTER_W-1:0] cl,
                             logic [DATA_W-1:0] val);
        // drop valid for a random gap once the burst runs out
        if (burst_left == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        req_ch.valid       = 1'b1;
        req_ch.action      = act;
        req_ch.cluster     = cl;
        req_ch.entry_value = val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(fat_apply(act, cl, val));
        action_count[act]++;
        @(negedge clk);
    endtask

    // Random word that never reads an entry holding unknown data
    task automatic send_random_word();
        t_action              act;
        logic [CLUSTER_W-1:0] cl;
        int unsigned          lim;
        int unsigned          stop;
        int unsigned          r;
        lim = entries_used();
        r   = $urandom_range(0, 99);
        if (r < 30)
            act = ACT_ALLOC;
        else if (r < 55)
            act = ACT_NEXT;
        else if (r < 75)
            act = ACT_FREE;
        else
            act = ACT_WRITE;
        cl = pick_cluster(lim);
        if (act == ACT_ALLOC && $urandom_range(0, 2) == 0)
            cl = '0;
        // turn a read of unknown data into a write that fills it
        if ((act == ACT_NEXT || act == ACT_FREE) && cl < lim && !written[cl])
            act = ACT_WRITE;
        if (act == ACT_ALLOC && (cl == 0 || cl < lim)) begin
            stop = scan_stop();
            if (stop < lim && !written[stop]) begin
                act = ACT_WRITE;
                cl  = CLUSTER_W'(stop);
            end
        end
        send_word(act, cl, pick_value());
    endtask

    // Hold the request side until every expected result word has come
    task automatic wait_for_results();
        req_ch.valid = 1'b0;
        burst_left   = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_sectors(logic [SECTORS_W-1:0] n);
        wait_for_results();
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = n;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow_sectors = n;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_load_table();
        int i;
        logic [DATA_W-1:0] val;
        set_sectors(1);
        for (i = 0; i < LOADED_SPAN; i++) begin
            // keep one entry in every sixteen free, fill the rest with nonzero values
            val = pick_value();
            if (i % 16 == 5)
                val = '0;
            else if (val == '0)
                val = CHAIN_END;
            send_word(ACT_WRITE, CLUSTER_W'(i), val);
        end
    endtask

    task automatic test_access_bounds();
        send_word(ACT_NEXT, 0, '0);
        send_word(ACT_NEXT, LOADED_SPAN - 1, '0);
        send_word(ACT_NEXT, LOADED_SPAN, '0);
        send_word(ACT_NEXT, TABLE_SIZE - 1, '0);
        send_word(ACT_WRITE, TABLE_SIZE - 1, 32'hDEAD_BEEF);
        send_word(ACT_FREE, 300, '0);
        send_word(ACT_WRITE, 5, '1);
        send_word(ACT_NEXT, 5, '0);
        send_word(ACT_FREE, 5, '0);
        send_word(ACT_NEXT, 5, '1);
    endtask

    task automatic test_allocate_cases();
        int unsigned k;
        send_word(ACT_ALLOC, 0, 32'h5555_5555);
        send_word(ACT_ALLOC, 7, '0);
        send_word(ACT_NEXT, 7, '0);
        send_word(ACT_ALLOC, 1000, '0);
        // link the new entry to itself
        if (scan_stop() == 0)
            send_word(ACT_WRITE, 0, CHAIN_END);
        k = scan_stop();
        if (k < entries_used()) begin
            send_word(ACT_ALLOC, CLUSTER_W'(k), '0);
            send_word(ACT_NEXT, CLUSTER_W'(k), '0);
        end
    endtask

    task automatic test_sector_extremes();
        set_sectors(0);
        send_word(ACT_NEXT, 0, '0);
        send_word(ACT_ALLOC, 0, '0);
        send_word(ACT_ALLOC, 5, '0);
        send_word(ACT_FREE, 0, '0);
        send_word(ACT_WRITE, 0, 32'h1234_5678);
        set_sectors(63);
        send_word(ACT_WRITE, TABLE_SIZE - 1, 32'h8000_0001);
        send_word(ACT_NEXT, TABLE_SIZE - 1, '0);
        set_sectors(32);
        send_word(ACT_FREE, TABLE_SIZE - 1, '0);
        send_word(ACT_NEXT, TABLE_SIZE - 1, '0);
    endtask

    task automatic test_table_full();
        int guard;
        set_sectors(1);
        guard = 0;
        // fill the single sector by allocation
        while (scan_stop() < entries_used() && guard < 2 * ENTRIES_PER_SECTOR) begin
            send_word(ACT_ALLOC, 0, '0);
            guard++;
        end
        send_word(ACT_ALLOC, 0, '0);
        send_word(ACT_ALLOC, 3, '0);
        send_word(ACT_NEXT, 3, '0);
        send_word(ACT_FREE, 40, '0);
        send_word(ACT_ALLOC, 3, '0);
    endtask

    task automatic test_random_mix();
        logic [SECTORS_W-1:0] plan [6];
        int p;
        int j;
        plan = '{6'd2, 6'd1, 6'd32, 6'd3, 6'd63, 6'd2};
        for (p = 0; p < 6; p++) begin
            set_sectors(plan[p]);
            for (j = 0; j < PHASE_WORDS; j++) begin
                if (p == 2 && j == PHASE_WORDS / 2)
                    wait_for_results();
                send_random_word();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and sequence
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : run_sequence
        int i;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_NEXT;
        req_ch.cluster     = '0;
        req_ch.entry_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        burst_left         = 0;
        shadow_sectors     = SECTORS_W'(RESET_SECTORS);
        for (i = 0; i < TABLE_SIZE; i++) begin
            shadow_table[i] = '0;
            written[i]      = 1'b0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_load_table();
        test_access_bounds();
        test_allocate_cases();
        test_sector_extremes();
        test_table_full();
        test_random_mix();

        // drain and let the block settle
        wait_for_results();
        repeat (20) @(posedge clk);
        $display("Checked %0d result words: %0d next, %0d allocate, %0d free, %0d write.",
                 checked_count, action_count[ACT_NEXT], action_count[ACT_ALLOC],
                 action_count[ACT_FREE], action_count[ACT_WRITE]);
        $display("Sector counts 0 to 63 used; %0d ok, %0d full, %0d out of range, %0d bad.",
                 status_count[STAT_OK], status_count[STAT_FULL],
                 status_count[STAT_RANGE], mismatch_count + stray_count);
        if (mismatch_count == 0 && stray_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------------
    initial begin : stall_pattern
        int unsigned mode;
        int unsigned hold;
        rsp_ch.ready = 1'b0;
        mode         = 0;
        hold         = 0;
        forever begin
            @(negedge clk);
            // switch between always ready, coin flips and long stalls
            if (hold == 0) begin
                mode = $urandom_range(0, 2);
                hold = $urandom_range(20, 80);
            end
            hold--;
            case (mode)
                0: rsp_ch.ready = 1'b1;
                1: rsp_ch.ready = $urandom_range(0, 1);
                default: rsp_ch.ready = ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge clk) begin : check_results
        chain_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                stray_count++;
                if (mismatch_count + stray_count <= SHOWN_MAX)
                    $display("Unexpected result word: value %h status %0d",
                             rsp_ch.result_value, rsp_ch.status);
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                status_count[want.status]++;
                if (rsp_ch.result_value !== want.value || rsp_ch.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count + stray_count <= SHOWN_MAX)
                        $display("Result word %0d: value %h status %0d, expected %h status %0d",
                                 checked_count, rsp_ch.result_value, rsp_ch.status,
                                 want.value, want.status);
                end
            end
        end
    end

    // Hang guard
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
